FILE: hdl/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Operation codes carried on the kind field
  localparam logic [2:0] KIND_PUT     = 3'd0;
  localparam logic [2:0] KIND_SET_RC  = 3'd1;
  localparam logic [2:0] KIND_SET_IDX = 3'd2;
  localparam logic [2:0] KIND_BACK    = 3'd3;
  localparam logic [2:0] KIND_CLEAR   = 3'd4;
  localparam logic [2:0] KIND_READ    = 3'd5;

  // Character and attribute constants
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] BLANK_CODE   = 8'h20;
  localparam logic [7:0] NUL_CODE     = 8'h00;
  localparam logic [7:0] RESET_COLOR  = 8'h07;

  // Controller to datapath commands
  typedef struct packed {
    logic ptr_clear;   // rewind sweep pointer, drop pending copy write
    logic fill;        // write blank at sweep pointer, advance
    logic fill_init;   // blank uses the power-up color
    logic copy;        // one step of the scroll copy
    logic put_char;    // write char at cursor and advance cursor
    logic newline;     // cursor to column 0 of next row (holds on last row)
    logic load_rc;     // load cursor from column/row fields
    logic div_load;    // start index to row/column split
    logic div_step;    // split step: row by reciprocal, then column
    logic back_move;   // move cursor back one cell
    logic write_zero;  // write character 0 at cursor
    logic cur_zero;    // cursor to origin
    logic rd_cell;     // read cell at clamped index
    logic load_out;    // load result register
    logic out_rd;      // result carries the read data
  } tcw_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic char_newline;
    logic last_col;
    logic last_row;
    logic rem_lt;
    logic copy_done;
    logic ptr_last;
  } tcw_sts_t;

endpackage

`default_nettype wire

FILE: hdl/tcw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [2:0]       kind_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire tcw_pkg::tcw_sts_t sts_i,
  output tcw_pkg::tcw_cmd_t     cmd_o
);

  typedef enum logic [7:0] {
    S_INIT    = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_BS_WR   = 8'b0000_0100,
    S_DIV     = 8'b0000_1000,
    S_COPY    = 8'b0001_0000,
    S_FILL    = 8'b0010_0000,
    S_RESP    = 8'b0100_0000,
    S_RESP_RD = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Sequencing
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.fill      = 1'b1;
        cmd_o.fill_init = 1'b1;
        if (sts_i.ptr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (kind_i)
            tcw_pkg::KIND_PUT: begin
              if (sts_i.char_newline) begin
                cmd_o.newline = 1'b1;
                if (sts_i.last_row) begin
                  cmd_o.ptr_clear = 1'b1;
                  state_d         = S_COPY;
                end else begin
                  state_d = S_RESP;
                end
              end else begin
                cmd_o.put_char = 1'b1;
                if (sts_i.last_col && sts_i.last_row) begin
                  cmd_o.ptr_clear = 1'b1;
                  state_d         = S_COPY;
                end else begin
                  state_d = S_RESP;
                end
              end
            end
            tcw_pkg::KIND_SET_RC: begin
              cmd_o.load_rc = 1'b1;
              state_d       = S_RESP;
            end
            tcw_pkg::KIND_SET_IDX: begin
              cmd_o.div_load = 1'b1;
              state_d        = S_DIV;
            end
            tcw_pkg::KIND_BACK: begin
              cmd_o.back_move = 1'b1;
              state_d         = S_BS_WR;
            end
            tcw_pkg::KIND_CLEAR: begin
              cmd_o.cur_zero  = 1'b1;
              cmd_o.ptr_clear = 1'b1;
              state_d         = S_FILL;
            end
            tcw_pkg::KIND_READ: begin
              cmd_o.rd_cell = 1'b1;
              state_d       = S_RESP_RD;
            end
            default: state_d = S_RESP;  // unused kinds only report the cursor
          endcase
        end
      end
      S_BS_WR: begin
        cmd_o.write_zero = 1'b1;
        state_d          = S_RESP;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.rem_lt) state_d = S_RESP;
      end
      S_COPY: begin
        cmd_o.copy = 1'b1;
        if (sts_i.copy_done) state_d = S_FILL;
      end
      S_FILL: begin
        cmd_o.fill = 1'b1;
        if (sts_i.ptr_last) state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_RESP_RD: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_rd   = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result word valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tcw_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_datapath #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [7:0]        text_color_i,
  input  wire logic [7:0]        char_code_i,
  input  wire logic [6:0]        column_i,
  input  wire logic [4:0]        row_i,
  input  wire logic [10:0]       cell_index_i,
  input  wire tcw_pkg::tcw_cmd_t cmd_i,
  output tcw_pkg::tcw_sts_t      sts_o,
  output logic [10:0]            cursor_pos_o,
  output logic [15:0]            read_entry_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  localparam logic [31:0] COL_MAX  = 32'(COLUMNS - 1);
  localparam logic [31:0] ROW_MAX  = 32'(ROWS - 1);
  localparam logic [31:0] CELL_NUM = 32'(CELLS);

  // Reciprocal of COLUMNS, exact for every index below 2**AW
  localparam int          QS    = AW + CW;
  localparam logic [31:0] RECIP = 32'(((1 << QS) + COLUMNS - 1) / COLUMNS);

  logic [15:0]   mem [CELLS];

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [7:0]    color_q;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] wptr_q, wptr_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] rem_q, rem_d;
  logic [15:0]   rdata_q;
  logic [10:0]   out_pos_q;
  logic [15:0]   out_entry_q;

  logic [AW-1:0] cur_addr;
  logic [AW-1:0] idx_clamped;
  logic [CW-1:0] col_sat;
  logic [RW-1:0] row_sat;
  logic          wrap;
  logic [31:0]   quot_full;
  logic [RW-1:0] quot;

  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [7:0]    blank_color;

  // Cursor address and field saturation
  assign cur_addr    = AW'(32'(row_q) * 32'(COLUMNS) + 32'(col_q));
  assign idx_clamped = (32'(cell_index_i) >= CELL_NUM) ? AW'(CELLS - 1) : AW'(cell_index_i);
  assign col_sat     = (32'(column_i) > COL_MAX) ? CW'(COLUMNS - 1) : CW'(column_i);
  assign row_sat     = (32'(row_i) > ROW_MAX) ? RW'(ROWS - 1) : RW'(row_i);

  // Row of the held index by reciprocal multiply
  assign quot_full = (32'(rem_q) * RECIP) >> QS;
  assign quot      = RW'(quot_full);

  // Status to the controller
  assign sts_o.char_newline = (char_code_i == tcw_pkg::NEWLINE_CODE);
  assign sts_o.last_col     = (32'(col_q) == COL_MAX);
  assign sts_o.last_row     = (32'(row_q) == ROW_MAX);
  assign sts_o.rem_lt       = (32'(rem_q) < 32'(COLUMNS));
  assign sts_o.copy_done    = (ptr_q == AW'(CELLS - COLUMNS));
  assign sts_o.ptr_last     = (ptr_q == AW'(CELLS - 1));

  assign wrap = cmd_i.newline || (cmd_i.put_char && sts_o.last_col);

  // Cursor registers, also the quotient/remainder of the index split
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    rem_d = rem_q;
    priority if (cmd_i.cur_zero) begin
      col_d = '0;
      row_d = '0;
    end else if (cmd_i.load_rc) begin
      col_d = col_sat;
      row_d = row_sat;
    end else if (cmd_i.div_load) begin
      rem_d = idx_clamped;
      row_d = '0;
    end else if (cmd_i.div_step) begin
      if (sts_o.rem_lt) begin
        col_d = CW'(rem_q);
      end else begin
        // quotient is exact, so the remainder is below COLUMNS next cycle
        rem_d = rem_q - AW'(32'(quot) * 32'(COLUMNS));
        row_d = quot;
      end
    end else if (wrap) begin
      // last row holds; the scroll sweep makes room
      col_d = '0;
      if (!sts_o.last_row) row_d = row_q + RW'(1);
    end else if (cmd_i.put_char) begin
      col_d = col_q + CW'(1);
    end else if (cmd_i.back_move) begin
      if (col_q != '0) begin
        col_d = col_q - CW'(1);
      end else if (row_q != '0) begin
        row_d = row_q - RW'(1);
        col_d = CW'(COLUMNS - 1);
      end
    end
  end

  // Sweep pointer for clear, scroll copy and blank fill
  always_comb begin
    ptr_d  = ptr_q;
    wptr_d = wptr_q;
    pend_d = pend_q;
    priority if (cmd_i.ptr_clear) begin
      ptr_d  = '0;
      pend_d = 1'b0;
    end else if (cmd_i.fill) begin
      ptr_d = ptr_q + AW'(1);
    end else if (cmd_i.copy) begin
      if (sts_o.copy_done) begin
        pend_d = 1'b0;
      end else begin
        wptr_d = ptr_q;
        pend_d = 1'b1;
        ptr_d  = ptr_q + AW'(1);
      end
    end
  end

  // Cell store port selection
  assign blank_color = cmd_i.fill_init ? tcw_pkg::RESET_COLOR : color_q;

  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wdata = {color_q, char_code_i};
    priority if (cmd_i.fill) begin
      we    = 1'b1;
      waddr = ptr_q;
      wdata = {blank_color, tcw_pkg::BLANK_CODE};
    end else if (cmd_i.copy && pend_q) begin
      we    = 1'b1;
      waddr = wptr_q;
      wdata = rdata_q;
    end else if (cmd_i.put_char) begin
      we    = 1'b1;
      waddr = cur_addr;
      wdata = {color_q, char_code_i};
    end else if (cmd_i.write_zero) begin
      we    = 1'b1;
      waddr = cur_addr;
      wdata = {color_q, tcw_pkg::NUL_CODE};
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = idx_clamped;
    priority if (cmd_i.rd_cell) begin
      re    = 1'b1;
      raddr = idx_clamped;
    end else if (cmd_i.copy && !sts_o.copy_done) begin
      re    = 1'b1;
      raddr = ptr_q + AW'(COLUMNS);
    end
  end

  // Cell store, registered read
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  // Result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_pos_q   <= 11'(cur_addr);
      out_entry_q <= cmd_i.out_rd ? rdata_q : 16'h0000;
    end
  end

  assign cursor_pos_o = out_pos_q;
  assign read_entry_o = out_entry_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      rem_q   <= '0;
      ptr_q   <= '0;
      wptr_q  <= '0;
      pend_q  <= 1'b0;
      color_q <= tcw_pkg::RESET_COLOR;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      rem_q  <= rem_d;
      ptr_q  <= ptr_d;
      wptr_q <= wptr_d;
      pend_q <= pend_d;
      if (cfg_we_i) color_q <= text_color_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/text_console_writer.sv
// Character-cell console: a screen store of COLUMNS x ROWS 16-bit cells (character in
// the low byte, color in the high byte) with a cursor. Each input word is one operation
// and gives exactly one result word holding the cursor position and, for a cell read,
// the cell content. The store has one write and one registered read per cycle. Set
// cursor by index splits the index: a reciprocal multiply gives the row, then the
// remainder gives the column. Clear walks the store one cell a cycle; a newline or
// wrap on the last row scrolls, copying and then blanking one cell a cycle. After
// reset the store is blanked in a clearing pass during which no input word is taken;
// color writes are accepted at any time. A result word waits in an output register,
// so the input side is free again as soon as it is loaded.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  text_color_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [6:0]  column_i,
  input  wire logic [4:0]  row_i,
  input  wire logic [10:0] cell_index_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [10:0]      cursor_pos_o,
  output logic [15:0]      read_entry_o
);

  tcw_pkg::tcw_cmd_t cmd;
  tcw_pkg::tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .text_color_i (text_color_i),
    .char_code_i  (char_code_i),
    .column_i     (column_i),
    .row_i        (row_i),
    .cell_index_i (cell_index_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cursor_pos_o (cursor_pos_o),
    .read_entry_o (read_entry_o)
  );

  // Reported cursor always points into the screen
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(cursor_pos_o) < 32'(COLUMNS * ROWS)))
    else $error("cursor position beyond the screen");

  // No store sweep runs while a word can be taken
  a_no_sweep_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!cmd.fill && !cmd.copy))
    else $error("store sweep active while input is open");

  // One word in flight: an accepted word closes the input for the next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input reopened right after accept");

endmodule

`default_nettype wire

FILE: test/tb_text_console_writer.sv
`timescale 1ns / 1ps

module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int COLS   = COLUMNS_DEF;
  localparam int ROWS_N = ROWS_DEF;
  localparam int CELLS  = COLS * ROWS_N;
  localparam int LAST   = CELLS - 1;

  // kinds 6 and 7 are unused codes; the block must leave everything alone
  localparam logic [2:0] KIND_IDLE6 = 3'd6;
  localparam logic [2:0] KIND_IDLE7 = 3'd7;

  localparam int LONG_HOLD = 400;
  localparam int PHASES    = 6;
  localparam int PHASE_OPS = 200;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  char_code;
    logic [6:0]  column;
    logic [4:0]  row;
    logic [10:0] cell_index;
  } console_op_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [15:0] read_entry;
  } console_res_t;

  // DUT ports
  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [7:0]  text_color_i = RESET_COLOR;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [2:0]  kind_i       = '0;
  logic [7:0]  char_code_i  = '0;
  logic [6:0]  column_i     = '0;
  logic [4:0]  row_i        = '0;
  logic [10:0] cell_index_i = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [10:0] cursor_pos_o;
  logic [15:0] read_entry_o;

  // Screen shadow: cells, cursor and attribute as the block should hold them
  logic [15:0] shadow_cells [CELLS];
  int          shadow_row;
  int          shadow_col;
  logic [7:0]  shadow_color;

  console_op_t  ops_pending [$];
  console_res_t results_due [$];

  // Traffic shaping, set per phase
  bit tx_calm;
  int rx_mode;
  int burst_left;
  int gap_left;
  int hold_left;
  int rx_phase;

  int errors;
  int words_in;
  int results_seen;
  int scroll_cnt;
  int clear_cnt;
  int read_cnt;

  console_op_t  op_now;
  console_res_t res_now;
  console_res_t due;

  text_console_writer i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .text_color_i (text_color_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .char_code_i  (char_code_i),
    .column_i     (column_i),
    .row_i        (row_i),
    .cell_index_i (cell_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cursor_pos_o (cursor_pos_o),
    .read_entry_o (read_entry_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [15:0] attr_cell(logic [7:0] ch);
    return {shadow_color, ch};
  endfunction

  function automatic int clamp_cell(logic [10:0] idx);
    return (int'(idx) >= CELLS) ? LAST : int'(idx);
  endfunction

  // Cursor to the next row; off the bottom the screen scrolls up one row
  task automatic line_feed();
    int k;
    shadow_row++;
    if (shadow_row >= ROWS_N) begin
      for (k = 0; k < CELLS - COLS; k++) shadow_cells[k] = shadow_cells[k + COLS];
      for (k = CELLS - COLS; k < CELLS; k++) shadow_cells[k] = attr_cell(BLANK_CODE);
      shadow_row = ROWS_N - 1;
      scroll_cnt++;
    end
    shadow_col = 0;
  endtask

  // Apply one console word to the shadow and work out its result word
  task automatic console_step(input console_op_t op, output console_res_t res);
    int          p;
    int          k;
    logic [15:0] entry;
    entry = '0;
    case (op.kind)
      KIND_PUT: begin
        if (op.char_code == NEWLINE_CODE) begin
          line_feed();
        end else begin
          shadow_cells[shadow_row * COLS + shadow_col] = attr_cell(op.char_code);
          shadow_col++;
          if (shadow_col >= COLS) line_feed();
        end
      end
      KIND_SET_RC: begin
        shadow_col = (int'(op.column) > COLS - 1) ? COLS - 1 : int'(op.column);
        shadow_row = (int'(op.row) > ROWS_N - 1) ? ROWS_N - 1 : int'(op.row);
      end
      KIND_SET_IDX: begin
        p = clamp_cell(op.cell_index);
        shadow_col = p % COLS;
        shadow_row = p / COLS;
      end
      KIND_BACK: begin
        if (shadow_col > 0) begin
          shadow_col--;
        end else if (shadow_row > 0) begin
          shadow_row--;
          shadow_col = COLS - 1;
        end
        shadow_cells[shadow_row * COLS + shadow_col] = attr_cell(NUL_CODE);
      end
      KIND_CLEAR: begin
        for (k = 0; k < CELLS; k++) shadow_cells[k] = attr_cell(BLANK_CODE);
        shadow_row = 0;
        shadow_col = 0;
        clear_cnt++;
      end
      KIND_READ: begin
        entry = shadow_cells[clamp_cell(op.cell_index)];
        read_cnt++;
      end
      default: ;
    endcase
    res.cursor_pos = 11'(shadow_row * COLS + shadow_col);
    res.read_entry = entry;
  endtask

  function automatic void queue_op(logic [2:0] k, logic [7:0] ch, logic [6:0] c,
                                   logic [4:0] r, logic [10:0] idx);
    console_op_t op;
    op.kind       = k;
    op.char_code  = ch;
    op.column     = c;
    op.row        = r;
    op.cell_index = idx;
    ops_pending.push_back(op);
  endfunction

  // Random traffic: text runs with reads of what was written, scrolls, backspaces, clears, noise
  task automatic add_random_ops(int n_ops);
    int         added;
    int         n_start;
    int         sel;
    int         r;
    int         c;
    int         len;
    int         j;
    int         base;
    logic [7:0] ch;
    added = 0;
    while (added < n_ops) begin
      n_start = ops_pending.size();
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        // text run at a known place, then read some of it back
        r = ($urandom_range(0, 3) == 0) ? ROWS_N - 1 : $urandom_range(0, ROWS_N - 1);
        c = $urandom_range(0, COLS - 20);
        len = $urandom_range(1, 18);
        queue_op(KIND_SET_RC, 8'($urandom), 7'(c), 5'(r), 11'($urandom));
        for (j = 0; j < len; j++) begin
          do ch = 8'($urandom); while (ch == NEWLINE_CODE);
          queue_op(KIND_PUT, ch, 7'($urandom), 5'($urandom), 11'($urandom));
        end
        base = r * COLS + c;
        for (j = $urandom_range(0, 3); j > 0; j--)
          queue_op(KIND_READ, 8'($urandom), 7'($urandom), 5'($urandom),
                   11'(base + $urandom_range(0, len - 1)));
        if ($urandom_range(0, 2) == 0)
          queue_op(KIND_PUT, NEWLINE_CODE, 7'($urandom), 5'($urandom), 11'($urandom));
      end else if (sel < 50) begin
        // write from near the end of the screen, so it can wrap and scroll
        queue_op(KIND_SET_IDX, 8'($urandom), 7'($urandom), 5'($urandom),
                 11'($urandom_range(CELLS - 8, LAST)));
        for (j = $urandom_range(1, 10); j > 0; j--)
          queue_op(KIND_PUT, 8'($urandom), 7'($urandom), 5'($urandom), 11'($urandom));
        queue_op(KIND_READ, 8'($urandom), 7'($urandom), 5'($urandom),
                 11'($urandom_range(CELLS - 2 * COLS, LAST)));
      end else if (sel < 60) begin
        // backspaces, often from column 0 or the origin
        r = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, ROWS_N - 1);
        c = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, COLS - 1);
        queue_op(KIND_SET_RC, 8'($urandom), 7'(c), 5'(r), 11'($urandom));
        for (j = $urandom_range(1, 4); j > 0; j--)
          queue_op(KIND_BACK, 8'($urandom), 7'($urandom), 5'($urandom), 11'($urandom));
        base = r * COLS + c;
        queue_op(KIND_READ, 8'($urandom), 7'($urandom), 5'($urandom),
                 11'((base > 0) ? base - 1 : 0));
      end else if (sel < 63) begin
        queue_op(KIND_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom), 11'($urandom));
        queue_op(KIND_READ, 8'($urandom), 7'($urandom), 5'($urandom), 11'($urandom));
      end else begin
        // noise: any kind, every field over its full width
        queue_op(3'($urandom_range(0, 7)), 8'($urandom), 7'($urandom), 5'($urandom),
                 11'($urandom));
      end
      added += ops_pending.size() - n_start;
    end
  endtask

  // Block is idle: nothing queued, on the wire or outstanding
  task automatic wait_idle();
    while (ops_pending.size() != 0 || in_valid_i || results_due.size() != 0)
      @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_color(logic [7:0] tone);
    @(posedge clk_i);
    cfg_we_i     <= 1'b1;
    text_color_i <= tone;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    shadow_color  = tone;
    @(negedge clk_i);
  endtask

  // Driver: bursts of words with random gaps, prediction at acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        console_step({kind_i, char_code_i, column_i, row_i, cell_index_i}, res_now);
        results_due.push_back(res_now);
        words_in++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (ops_pending.size() != 0) begin
          op_now = ops_pending.pop_front();
          kind_i       <= op_now.kind;
          char_code_i  <= op_now.char_code;
          column_i     <= op_now.column;
          row_i        <= op_now.row;
          cell_index_i <= op_now.cell_index;
          in_valid_i   <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = tx_calm ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result word, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (results_due.size() == 0) begin
          $error("unexpected result word: cursor_pos %0d read_entry %h",
                 cursor_pos_o, read_entry_o);
          errors++;
        end else begin
          due = results_due.pop_front();
          if (cursor_pos_o !== due.cursor_pos) begin
            $error("cursor_pos: expected %0d, got %0d", due.cursor_pos, cursor_pos_o);
            errors++;
          end
          if (read_entry_o !== due.read_entry) begin
            $error("read_entry: expected %h, got %h", due.read_entry, read_entry_o);
            errors++;
          end
        end
        results_seen++;
        // long hold so the block backs up and stalls its input
        if (results_seen == 150 || results_seen == 900) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 9) >= 3);
          default: begin
            rx_phase = (rx_phase + 1) % 7;
            out_ready_i <= (rx_phase >= 3);
          end
        endcase
      end
    end
  end

  // Main sequence
  initial begin
    int         k;
    int         ph;
    logic [7:0] tone;
    for (k = 0; k < CELLS; k++) shadow_cells[k] = {RESET_COLOR, BLANK_CODE};
    shadow_color = RESET_COLOR;
    shadow_row   = 0;
    shadow_col   = 0;
    tx_calm      = 1'b0;
    rx_mode      = 1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset contents, extremes, wrap and scroll, backspace corners
    queue_op(KIND_READ,    8'h00, 7'd0,   5'd0,  11'd0);
    queue_op(KIND_PUT,     8'h41, 7'd0,   5'd0,  11'd0);
    queue_op(KIND_PUT,     8'hFF, 7'h7F,  5'h1F, 11'h7FF);
    queue_op(KIND_PUT,     8'h00, 7'd0,   5'd0,  11'd0);
    queue_op(KIND_READ,    8'h00, 7'd0,   5'd0,  11'd1);
    queue_op(KIND_BACK,    8'h00, 7'd0,   5'd0,  11'd0);
    queue_op(KIND_READ,    8'h00, 7'd0,   5'd0,  11'd2);
    queue_op(KIND_SET_RC,  8'h00, 7'h7F,  5'h1F, 11'd0);
    queue_op(KIND_PUT,     8'h5A, 7'd0,   5'd0,  11'd0);
    queue_op(KIND_READ,    8'h00, 7'd0,   5'd0,  11'(LAST - COLS));
    queue_op(KIND_READ,    8'h00, 7'd0,   5'd0,  11'(LAST));
    queue_op(KIND_PUT,     NEWLINE_CODE, 7'd0, 5'd0, 11'd0);
    queue_op(KIND_SET_IDX, 8'h00, 7'd0,   5'd0,  11'h7FF);
    queue_op(KIND_READ,    8'h00, 7'd0,   5'd0,  11'h7FF);
    queue_op(KIND_SET_RC,  8'h00, 7'd0,   5'd0,  11'd0);
    queue_op(KIND_BACK,    8'h00, 7'd0,   5'd0,  11'd0);
    queue_op(KIND_READ,    8'h00, 7'd0,   5'd0,  11'd0);
    queue_op(KIND_SET_RC,  8'h00, 7'd0,   5'd5,  11'd0);
    queue_op(KIND_BACK,    8'h00, 7'd0,   5'd0,  11'd0);
    queue_op(KIND_READ,    8'h00, 7'd0,   5'd0,  11'(5 * COLS - 1));
    queue_op(KIND_SET_IDX, 8'h00, 7'd0,   5'd0,  11'(CELLS));
    queue_op(KIND_IDLE6,   8'hFF, 7'h7F,  5'h1F, 11'h7FF);
    queue_op(KIND_IDLE7,   8'h0A, 7'h55,  5'h0A, 11'h555);
    queue_op(KIND_CLEAR,   8'h00, 7'd0,   5'd0,  11'd0);
    queue_op(KIND_READ,    8'h00, 7'd0,   5'd0,  11'(LAST));
    wait_idle();

    // random phases, one color setting each; the third has no idling at all
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       tone = 8'hFF;
        1:       tone = 8'h00;
        3:       tone = 8'h1E;
        4:       tone = 8'hF0;
        default: tone = 8'($urandom);
      endcase
      write_color(tone);
      tx_calm = (ph == 2);
      rx_mode = (ph == 2) ? 0 : 1 + (ph % 2);
      add_random_ops(PHASE_OPS);
      wait_idle();
    end

    repeat (20) @(negedge clk_i);
    $display("Sent %0d console words under %0d color settings: %0d cell reads, %0d scrolls,",
             words_in, PHASES + 1, read_cnt, scroll_cnt);
    $display("%0d clears; %0d result words checked, %0d mismatches.",
             clear_cnt, results_seen, errors);
    if (errors == 0) begin
      $display("text_console_writer regression: pass");
    end else begin
      $display("text_console_writer regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #60_000_000;
    $display("text_console_writer regression: fail");
    $finish;
  end

endmodule

FILE: text_console_writer.f
hdl/tcw_pkg.sv
hdl/tcw_ctrl.sv
hdl/tcw_datapath.sv
hdl/text_console_writer.sv
test/tb_text_console_writer.sv
